// ===== rtl/lrp_pkg.sv =====
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared types, sizes and codes of the table-driven LR parser.
// ----------------------------------------------------------------------------
package lrp_pkg;

	localparam int NUM_STATES       = 64;
	localparam int NUM_TERMINALS    = 16;
	localparam int NUM_NONTERMINALS = 16;
	localparam int NUM_PRODUCTIONS  = 32;
	localparam int STACK_DEPTH      = 64;
	localparam int MAX_REDUCTIONS   = 32;

	// Fixed field widths of the word formats.
	localparam int OP_W    = 2;
	localparam int IDX_W   = 6;
	localparam int TERM_W  = 4;
	localparam int NT_W    = 4;
	localparam int KIND_W  = 2;
	localparam int TGT_W   = 6;
	localparam int PIDX_W  = 5;
	localparam int LEN_W   = 4;
	localparam int SEM_W   = 8;
	localparam int RK_W    = 3;

	// Derived storage sizes.
	localparam int ACT_DEPTH  = NUM_STATES * NUM_TERMINALS;
	localparam int GOTO_DEPTH = NUM_STATES * NUM_NONTERMINALS;
	localparam int ACT_AW     = $clog2(ACT_DEPTH);
	localparam int GOTO_AW    = $clog2(GOTO_DEPTH);
	localparam int PROD_AW    = $clog2(NUM_PRODUCTIONS);
	localparam int SP_W       = $clog2(STACK_DEPTH);
	localparam int DEPTH_W    = SP_W + 1;
	localparam int RED_W      = $clog2(MAX_REDUCTIONS + 1);
	localparam int ACT_DW     = KIND_W + TGT_W;
	localparam int PROD_DW    = NT_W + LEN_W + SEM_W;

	typedef enum logic [OP_W-1:0] {
		OP_TOKEN  = 2'd0,
		OP_ACTION = 2'd1,
		OP_GOTO   = 2'd2,
		OP_PROD   = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		AK_EMPTY  = 2'd0,
		AK_SHIFT  = 2'd1,
		AK_REDUCE = 2'd2,
		AK_ACCEPT = 2'd3
	} act_t;

	typedef enum logic [RK_W-1:0] {
		RK_LOAD     = 3'd0,
		RK_REDUCED  = 3'd1,
		RK_SHIFTED  = 3'd2,
		RK_ACCEPTED = 3'd3,
		RK_ERROR    = 3'd4
	} rk_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ACT,
		S_PROD,
		S_UNDER,
		S_GOTO,
		S_ERR
	} fsm_t;

endpackage

// ===== rtl/lrp_if.sv =====
// ----------------------------------------------------------------------------
// lrp_req_if / lrp_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface lrp_req_if;
	logic                        valid;
	logic                        ready;
	logic [lrp_pkg::OP_W-1:0]    operation;
	logic [lrp_pkg::IDX_W-1:0]   state_index;
	logic [lrp_pkg::TERM_W-1:0]  terminal_index;
	logic [lrp_pkg::NT_W-1:0]    nonterminal_index;
	logic [lrp_pkg::KIND_W-1:0]  action_kind;
	logic [lrp_pkg::TGT_W-1:0]   action_target;
	logic [lrp_pkg::TGT_W-1:0]   goto_target;
	logic [lrp_pkg::PIDX_W-1:0]  production_index;
	logic [lrp_pkg::LEN_W-1:0]   rhs_length;
	logic [lrp_pkg::SEM_W-1:0]   semantic_id;

	modport source (output valid, operation, state_index, terminal_index, nonterminal_index,
		action_kind, action_target, goto_target, production_index, rhs_length, semantic_id,
		input ready);
	modport sink (input valid, operation, state_index, terminal_index, nonterminal_index,
		action_kind, action_target, goto_target, production_index, rhs_length, semantic_id,
		output ready);
endinterface

interface lrp_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [lrp_pkg::RK_W-1:0]    result_kind;
	logic [lrp_pkg::SEM_W-1:0]   reduced_semantic;
	logic [lrp_pkg::PIDX_W-1:0]  reduced_production;
	logic                        last;

	modport source (output valid, result_kind, reduced_semantic, reduced_production, last,
		input ready);
	modport sink (input valid, result_kind, reduced_semantic, reduced_production, last,
		output ready);
endinterface

// ===== rtl/lrp_ram.sv =====
// ----------------------------------------------------------------------------
// lrp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lrp_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/lr_table_driven_parser.sv =====
// ----------------------------------------------------------------------------
// lr_table_driven_parser
// Table-driven LR shift-reduce parser with loadable action, goto and
// production tables.
// ----------------------------------------------------------------------------
// After reset the block clears all 1024 entries of the action table and
// accepts no word during that pass. A load word is answered directly from
// the idle state. A token word fetches its action and finishes a shift,
// accept or error, or first runs through every reduction it triggers, in
// which the action, production, stack and goto reads each pass through a
// synchronous memory with registered output. A word is taken only while
// the sequencer is idle and the response register is free or being emptied;
// a stalled response stalls the sequencer.
module lr_table_driven_parser (
	input logic   clk,
	input logic   arst_n,
	lrp_req_if.sink   req,
	lrp_rsp_if.source rsp
);

	// Sequencer state and parse registers.
	lrp_pkg::fsm_t                   state_q, state_d;
	logic [lrp_pkg::DEPTH_W-1:0]     depth_q, depth_d;
	logic [lrp_pkg::TGT_W-1:0]       top_q, top_d;
	logic [lrp_pkg::RED_W-1:0]       red_q, red_d;
	logic [lrp_pkg::ACT_AW-1:0]      clr_q;
	logic [lrp_pkg::TERM_W-1:0]      term_q;
	logic [lrp_pkg::PIDX_W-1:0]      prod_q;
	logic [lrp_pkg::NT_W-1:0]        left_q;
	logic [lrp_pkg::SEM_W-1:0]       sem_q;
	logic [lrp_pkg::DEPTH_W-1:0]     nd_q;
	logic                            under_zero_q;

	// Response register.
	logic                            out_valid_q;
	lrp_pkg::rk_t                    out_kind_q;
	logic [lrp_pkg::SEM_W-1:0]       out_sem_q;
	logic [lrp_pkg::PIDX_W-1:0]      out_prod_q;
	logic                            out_last_q;

	logic                            can_emit;
	logic                            emit;
	lrp_pkg::rk_t                    emit_kind;
	logic                            emit_last;
	logic                            stack_reset;
	logic                            accept;

	// Memory ports.
	logic                            act_we, act_re;
	logic [lrp_pkg::ACT_AW-1:0]      act_waddr, act_raddr;
	logic [lrp_pkg::ACT_DW-1:0]      act_wdata, act_rdata;
	logic                            goto_we, goto_re;
	logic [lrp_pkg::GOTO_AW-1:0]     goto_waddr, goto_raddr;
	logic [lrp_pkg::TGT_W-1:0]       goto_rdata;
	logic                            prod_we, prod_re;
	logic [lrp_pkg::PROD_DW-1:0]     prod_rdata;
	logic                            stk_we, stk_re;
	logic [lrp_pkg::SP_W-1:0]        stk_waddr, stk_raddr;
	logic [lrp_pkg::TGT_W-1:0]       stk_wdata, stk_rdata;

	// Decoded memory words.
	lrp_pkg::act_t                   act_kind;
	logic [lrp_pkg::TGT_W-1:0]       act_tgt;
	logic [lrp_pkg::NT_W-1:0]        pd_left;
	logic [lrp_pkg::LEN_W-1:0]       pd_len;
	logic [lrp_pkg::SEM_W-1:0]       pd_sem;
	logic [lrp_pkg::DEPTH_W-1:0]     nd;
	logic [lrp_pkg::TGT_W-1:0]       under;

	// Capture enables for the per-step values latched by the sequencer.
	logic                            cap_term, cap_prod, cap_pd;

	assign act_kind = lrp_pkg::act_t'(act_rdata[lrp_pkg::ACT_DW-1:lrp_pkg::TGT_W]);
	assign act_tgt  = act_rdata[lrp_pkg::TGT_W-1:0];
	assign pd_left  = prod_rdata[lrp_pkg::PROD_DW-1:lrp_pkg::LEN_W+lrp_pkg::SEM_W];
	assign pd_len   = prod_rdata[lrp_pkg::LEN_W+lrp_pkg::SEM_W-1:lrp_pkg::SEM_W];
	assign pd_sem   = prod_rdata[lrp_pkg::SEM_W-1:0];
	assign nd       = depth_q - lrp_pkg::DEPTH_W'(pd_len);
	// The bottom entry of the stack is never written; it always reads as state zero.
	assign under    = under_zero_q ? '0 : stk_rdata;

	assign can_emit  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == lrp_pkg::S_IDLE) && can_emit;
	assign accept    = req.valid && req.ready;

	always_comb begin
		state_d     = state_q;
		depth_d     = depth_q;
		top_d       = top_q;
		red_d       = red_q;
		emit        = 1'b0;
		emit_kind   = lrp_pkg::RK_ERROR;
		emit_last   = 1'b1;
		stack_reset = 1'b0;
		cap_term    = 1'b0;
		cap_prod    = 1'b0;
		cap_pd      = 1'b0;
		act_we      = 1'b0;
		act_waddr   = lrp_pkg::ACT_AW'(req.state_index * lrp_pkg::NUM_TERMINALS
			+ req.terminal_index);
		act_wdata   = {req.action_kind, req.action_target};
		act_re      = 1'b0;
		act_raddr   = lrp_pkg::ACT_AW'(top_q * lrp_pkg::NUM_TERMINALS + req.terminal_index);
		goto_we     = 1'b0;
		goto_waddr  = lrp_pkg::GOTO_AW'(req.state_index * lrp_pkg::NUM_NONTERMINALS
			+ req.nonterminal_index);
		goto_re     = 1'b0;
		goto_raddr  = lrp_pkg::GOTO_AW'(under * lrp_pkg::NUM_NONTERMINALS + left_q);
		prod_we     = 1'b0;
		prod_re     = 1'b0;
		stk_we      = 1'b0;
		stk_waddr   = depth_q[lrp_pkg::SP_W-1:0];
		stk_wdata   = act_tgt;
		stk_re      = 1'b0;
		stk_raddr   = lrp_pkg::SP_W'(nd - lrp_pkg::DEPTH_W'(1));

		unique case (state_q)
			lrp_pkg::S_CLEAR: begin
				act_we    = 1'b1;
				act_waddr = clr_q;
				act_wdata = '0;
				if (clr_q == lrp_pkg::ACT_AW'(lrp_pkg::ACT_DEPTH - 1)) begin
					state_d = lrp_pkg::S_IDLE;
				end
			end
			lrp_pkg::S_IDLE: begin
				if (accept) begin
					case (lrp_pkg::op_t'(req.operation))
						lrp_pkg::OP_ACTION: begin
							act_we    = int'(req.state_index) < lrp_pkg::NUM_STATES
								&& int'(req.terminal_index) < lrp_pkg::NUM_TERMINALS;
							emit      = 1'b1;
							emit_kind = lrp_pkg::RK_LOAD;
						end
						lrp_pkg::OP_GOTO: begin
							goto_we   = int'(req.state_index) < lrp_pkg::NUM_STATES
								&& int'(req.nonterminal_index) < lrp_pkg::NUM_NONTERMINALS;
							emit      = 1'b1;
							emit_kind = lrp_pkg::RK_LOAD;
						end
						lrp_pkg::OP_PROD: begin
							prod_we   = int'(req.production_index) < lrp_pkg::NUM_PRODUCTIONS;
							emit      = 1'b1;
							emit_kind = lrp_pkg::RK_LOAD;
						end
						default: begin
							if (int'(req.terminal_index) >= lrp_pkg::NUM_TERMINALS
									|| int'(top_q) >= lrp_pkg::NUM_STATES) begin
								emit        = 1'b1;
								stack_reset = 1'b1;
							end else begin
								act_re   = 1'b1;
								cap_term = 1'b1;
								red_d    = '0;
								state_d  = lrp_pkg::S_ACT;
							end
						end
					endcase
				end
			end
			lrp_pkg::S_ACT: begin
				if (can_emit) begin
					state_d = lrp_pkg::S_IDLE;
					case (act_kind)
						lrp_pkg::AK_ACCEPT: begin
							emit        = 1'b1;
							emit_kind   = lrp_pkg::RK_ACCEPTED;
							stack_reset = 1'b1;
						end
						lrp_pkg::AK_SHIFT: begin
							emit = 1'b1;
							if (int'(depth_q) >= lrp_pkg::STACK_DEPTH) begin
								stack_reset = 1'b1;
							end else begin
								emit_kind = lrp_pkg::RK_SHIFTED;
								stk_we    = 1'b1;
								depth_d   = depth_q + lrp_pkg::DEPTH_W'(1);
								top_d     = act_tgt;
							end
						end
						lrp_pkg::AK_REDUCE: begin
							if (int'(red_q) >= lrp_pkg::MAX_REDUCTIONS
									|| int'(act_tgt) >= lrp_pkg::NUM_PRODUCTIONS) begin
								emit        = 1'b1;
								stack_reset = 1'b1;
							end else begin
								prod_re  = 1'b1;
								cap_prod = 1'b1;
								state_d  = lrp_pkg::S_PROD;
							end
						end
						default: begin
							emit        = 1'b1;
							stack_reset = 1'b1;
						end
					endcase
				end
			end
			lrp_pkg::S_PROD: begin
				if (can_emit) begin
					if (int'(pd_len) >= int'(depth_q)
							|| int'(pd_left) >= lrp_pkg::NUM_NONTERMINALS
							|| int'(nd) >= lrp_pkg::STACK_DEPTH) begin
						emit        = 1'b1;
						stack_reset = 1'b1;
						state_d     = lrp_pkg::S_IDLE;
					end else begin
						stk_re  = 1'b1;
						cap_pd  = 1'b1;
						state_d = lrp_pkg::S_UNDER;
					end
				end
			end
			lrp_pkg::S_UNDER: begin
				if (can_emit) begin
					if (int'(under) >= lrp_pkg::NUM_STATES) begin
						emit        = 1'b1;
						stack_reset = 1'b1;
						state_d     = lrp_pkg::S_IDLE;
					end else begin
						goto_re = 1'b1;
						state_d = lrp_pkg::S_GOTO;
					end
				end
			end
			lrp_pkg::S_GOTO: begin
				if (can_emit) begin
					// Replace the popped symbols by the goto state and report the reduction.
					stk_we    = 1'b1;
					stk_waddr = nd_q[lrp_pkg::SP_W-1:0];
					stk_wdata = goto_rdata;
					depth_d   = nd_q + lrp_pkg::DEPTH_W'(1);
					top_d     = goto_rdata;
					red_d     = red_q + lrp_pkg::RED_W'(1);
					emit      = 1'b1;
					emit_kind = lrp_pkg::RK_REDUCED;
					emit_last = 1'b0;
					if (int'(goto_rdata) >= lrp_pkg::NUM_STATES) begin
						state_d = lrp_pkg::S_ERR;
					end else begin
						act_re    = 1'b1;
						act_raddr = lrp_pkg::ACT_AW'(goto_rdata * lrp_pkg::NUM_TERMINALS
							+ term_q);
						state_d   = lrp_pkg::S_ACT;
					end
				end
			end
			lrp_pkg::S_ERR: begin
				if (can_emit) begin
					emit        = 1'b1;
					stack_reset = 1'b1;
					state_d     = lrp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lrp_pkg::S_IDLE;
			end
		endcase

		if (stack_reset) begin
			depth_d = lrp_pkg::DEPTH_W'(1);
			top_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lrp_pkg::S_CLEAR;
			clr_q       <= '0;
			depth_q     <= lrp_pkg::DEPTH_W'(1);
			top_q       <= '0;
			red_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			top_q   <= top_d;
			red_q   <= red_d;
			if (state_q == lrp_pkg::S_CLEAR) begin
				clr_q <= clr_q + lrp_pkg::ACT_AW'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= emit_kind;
			out_last_q <= emit_last;
			out_sem_q  <= (emit_kind == lrp_pkg::RK_REDUCED) ? sem_q : '0;
			out_prod_q <= (emit_kind == lrp_pkg::RK_REDUCED) ? prod_q : '0;
		end
		if (cap_term) begin
			term_q <= req.terminal_index;
		end
		if (cap_prod) begin
			prod_q <= act_tgt[lrp_pkg::PIDX_W-1:0];
		end
		if (cap_pd) begin
			left_q       <= pd_left;
			sem_q        <= pd_sem;
			nd_q         <= nd;
			under_zero_q <= (nd == lrp_pkg::DEPTH_W'(1));
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.result_kind        = out_kind_q;
	assign rsp.reduced_semantic   = out_sem_q;
	assign rsp.reduced_production = out_prod_q;
	assign rsp.last               = out_last_q;

	lrp_ram #(.DEPTH(lrp_pkg::ACT_DEPTH), .WIDTH(lrp_pkg::ACT_DW)) u_act_ram (
		.clk   (clk),
		.we    (act_we),
		.waddr (act_waddr),
		.wdata (act_wdata),
		.re    (act_re),
		.raddr (act_raddr),
		.rdata (act_rdata)
	);

	lrp_ram #(.DEPTH(lrp_pkg::GOTO_DEPTH), .WIDTH(lrp_pkg::TGT_W)) u_goto_ram (
		.clk   (clk),
		.we    (goto_we),
		.waddr (goto_waddr),
		.wdata (req.goto_target),
		.re    (goto_re),
		.raddr (goto_raddr),
		.rdata (goto_rdata)
	);

	lrp_ram #(.DEPTH(lrp_pkg::NUM_PRODUCTIONS), .WIDTH(lrp_pkg::PROD_DW)) u_prod_ram (
		.clk   (clk),
		.we    (prod_we),
		.waddr (req.production_index[lrp_pkg::PROD_AW-1:0]),
		.wdata ({req.nonterminal_index, req.rhs_length, req.semantic_id}),
		.re    (prod_re),
		.raddr (act_tgt[lrp_pkg::PROD_AW-1:0]),
		.rdata (prod_rdata)
	);

	lrp_ram #(.DEPTH(lrp_pkg::STACK_DEPTH), .WIDTH(lrp_pkg::TGT_W)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

endmodule

// ===== rtl/lrp_checker.sv =====
// ----------------------------------------------------------------------------
// lrp_checker
// Port-level checks of the LR parser, bound to the top level.
// ----------------------------------------------------------------------------
module lrp_checker (
	input logic clk,
	input logic arst_n,
	lrp_req_if.sink   req,
	lrp_rsp_if.source rsp
);

	// A stalled response word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_kind)
		&& $stable(rsp.last))
		else $error("stalled response word changed");

	// A load word is answered in the next cycle with a final load result.
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.operation != lrp_pkg::OP_TOKEN |=>
		rsp.valid && rsp.result_kind == lrp_pkg::RK_LOAD && rsp.last)
		else $error("load word not answered");

	// Only reductions are followed by further results of the same word.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.result_kind == lrp_pkg::RK_REDUCED) == !rsp.last)
		else $error("last flag disagrees with result kind");

	// Results other than reductions carry no production.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.result_kind != lrp_pkg::RK_REDUCED |->
		rsp.reduced_semantic == '0 && rsp.reduced_production == '0)
		else $error("non-reduction result carries a production");

endmodule

bind lr_table_driven_parser lrp_checker u_lrp_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);
